[hdl/keyword_operator_tokenizer_assert.svh]
// ----------------------------------------------------------------------------
// keyword_operator_tokenizer_assert.svh
// Assertion macros shared by the tokenizer RTL. All of them sample on the
// rising edge of clk and are disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef KEYWORD_OPERATOR_TOKENIZER_ASSERT_SVH
`define KEYWORD_OPERATOR_TOKENIZER_ASSERT_SVH

// antecedent holds -> consequent holds in the same cycle
`define KOT_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent holds -> consequent holds in the next cycle
`define KOT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// condition holds in every cycle out of reset
`define KOT_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

`endif

[hdl/kot_pkg.sv]
// ----------------------------------------------------------------------------
// kot_pkg
// Word types, token kinds, pending classes and character constants of the
// keyword/operator tokenizer.
// ----------------------------------------------------------------------------
package kot_pkg;

    typedef struct packed {
        logic       has_byte;
        logic [7:0] char_byte;
        logic       end_of_input;
    } src_word_t;

    typedef struct packed {
        logic [4:0]  token_kind;
        logic [15:0] token_start;
        logic [7:0]  token_length;
        logic        last_of_run;
        logic        offset_wrapped;
    } tok_word_t;

    typedef enum logic [2:0] {
        PC_NONE   = 3'd0,
        PC_IDENT  = 3'd1,
        PC_NUMBER = 3'd2,
        PC_EQ     = 3'd3,
        PC_GT     = 3'd4,
        PC_LT     = 3'd5
    } pclass_t;

    localparam logic [4:0] K_IDENT  = 5'd0;
    localparam logic [4:0] K_NUMBER = 5'd1;
    localparam logic [4:0] K_PLUS   = 5'd2;
    localparam logic [4:0] K_MINUS  = 5'd3;
    localparam logic [4:0] K_MUL    = 5'd4;
    localparam logic [4:0] K_DIV    = 5'd5;
    localparam logic [4:0] K_ASSIGN = 5'd6;
    localparam logic [4:0] K_LPAREN = 5'd7;
    localparam logic [4:0] K_RPAREN = 5'd8;
    localparam logic [4:0] K_LBRACE = 5'd9;
    localparam logic [4:0] K_RBRACE = 5'd10;
    localparam logic [4:0] K_IF     = 5'd11;
    localparam logic [4:0] K_GEQ    = 5'd15;
    localparam logic [4:0] K_LEQ    = 5'd16;
    localparam logic [4:0] K_EOF    = 5'd17;

    localparam logic [7:0] CH_US = 8'h5F;  // '_'
    localparam logic [7:0] CH_EQ = 8'h3D;  // '='
    localparam logic [7:0] CH_GT = 8'h3E;
    localparam logic [7:0] CH_LT = 8'h3C;

    // keyword text, padded to 8 places; order gives kind K_IF + index
    localparam int unsigned KW_COUNT = 4;
    localparam logic [7:0] KW_TEXT [KW_COUNT][8] = '{
        '{8'h69, 8'h66, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},  // if
        '{8'h65, 8'h6C, 8'h73, 8'h65, 8'h00, 8'h00, 8'h00, 8'h00},  // else
        '{8'h77, 8'h68, 8'h69, 8'h6C, 8'h65, 8'h00, 8'h00, 8'h00},  // while
        '{8'h70, 8'h72, 8'h69, 8'h6E, 8'h74, 8'h00, 8'h00, 8'h00}   // print
    };
    localparam int unsigned KW_LEN [KW_COUNT] = '{2, 4, 5, 5};

    localparam int unsigned QUEUE_DEPTH = 8;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned MAX_PER_ITEM = 3;

    function automatic logic is_alpha(logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    endfunction

    function automatic logic is_digit(logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_space(logic [7:0] c);
        return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    // single-character operator kinds; bit 5 flags a match
    function automatic logic [5:0] op_kind(logic [7:0] c);
        logic [5:0] r;
        r = '0;
        unique case (c)
            8'h2B:   r = {1'b1, K_PLUS};
            8'h2D:   r = {1'b1, K_MINUS};
            8'h2A:   r = {1'b1, K_MUL};
            8'h2F:   r = {1'b1, K_DIV};
            8'h28:   r = {1'b1, K_LPAREN};
            8'h29:   r = {1'b1, K_RPAREN};
            8'h7B:   r = {1'b1, K_LBRACE};
            8'h7D:   r = {1'b1, K_RBRACE};
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

[hdl/keyword_operator_tokenizer.sv]
// ----------------------------------------------------------------------------
// keyword_operator_tokenizer
// Streaming lexer: one source byte per word in, tokens (kind, start, length)
// out through a small result queue.
// ----------------------------------------------------------------------------
// A source word is taken every cycle while tok_stall allows the queue to
// drain. Each word is registered, then classified combinationally against
// the pending-token state, and the zero to three tokens it yields are
// written into an 8-entry result queue; with the queue empty, a token is
// on tok_data once its word has left the input register and been queued.
// src_stall rises only while fewer than three queue slots are free, so
// throughput is one source word per cycle unless the output side stalls.
module keyword_operator_tokenizer #(
    parameter int unsigned OFFSET_WIDTH  = 16,
    parameter int unsigned MAX_TOKEN_LEN = 255
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                src_valid,
    output logic                src_stall,
    input  kot_pkg::src_word_t  src_data,
    output logic                tok_valid,
    input  logic                tok_stall,
    output kot_pkg::tok_word_t  tok_data
);

    `include "keyword_operator_tokenizer_assert.svh"

    localparam int unsigned LEN_W = $clog2(MAX_TOKEN_LEN + 1);
    localparam logic [LEN_W-1:0]        LEN_MAX = LEN_W'(MAX_TOKEN_LEN);
    localparam logic [OFFSET_WIDTH-1:0] OFF_MAX = '1;
    localparam int unsigned QW = kot_pkg::QPTR_W;
    localparam int unsigned CW = kot_pkg::QCNT_W;
    localparam logic [CW-1:0] QDEPTH = CW'(kot_pkg::QUEUE_DEPTH);

    // ---------------------------------------------------------------- helpers

    function automatic logic [LEN_W-1:0] len_inc(logic [LEN_W-1:0] len);
        return (len < LEN_MAX) ? len + LEN_W'(1) : len;
    endfunction

    // drop keyword flags that no longer match after character c at place len
    function automatic logic [3:0] kw_step(logic [LEN_W-1:0] len, logic [3:0] flags,
                                           logic [7:0] c);
        logic [3:0] f;
        f = flags;
        for (int k = 0; k < kot_pkg::KW_COUNT; k++) begin
            if (!(len < LEN_W'(kot_pkg::KW_LEN[k]) &&
                  kot_pkg::KW_TEXT[k][len[2:0]] == c))
                f[k] = 1'b0;
        end
        return f;
    endfunction

    function automatic kot_pkg::tok_word_t make_word(logic [4:0] kind,
                                                     logic [OFFSET_WIDTH-1:0] start,
                                                     logic [LEN_W-1:0] len,
                                                     logic wrapped);
        kot_pkg::tok_word_t w;
        logic [31:0] start_w;
        logic [31:0] len_w;
        start_w = 32'(start);
        len_w = 32'(len);
        w.token_kind = kind;
        w.token_start = start_w[15:0];
        w.token_length = len_w[7:0];
        w.last_of_run = 1'b0;
        w.offset_wrapped = wrapped;
        return w;
    endfunction

    function automatic kot_pkg::tok_word_t flush_word(kot_pkg::pclass_t pc,
                                                      logic [OFFSET_WIDTH-1:0] start,
                                                      logic [LEN_W-1:0] len,
                                                      logic [3:0] flags,
                                                      logic wrapped);
        logic [4:0] kind;
        logic [LEN_W-1:0] l;
        kind = kot_pkg::K_IDENT;
        l = LEN_W'(1);
        unique case (pc)
            kot_pkg::PC_IDENT:
            begin
                l = len;
                for (int k = 0; k < kot_pkg::KW_COUNT; k++) begin
                    if (flags[k] && len == LEN_W'(kot_pkg::KW_LEN[k]))
                        kind = kot_pkg::K_IF + 5'(k);
                end
            end
            kot_pkg::PC_NUMBER:
            begin
                kind = kot_pkg::K_NUMBER;
                l = len;
            end
            kot_pkg::PC_EQ:     kind = kot_pkg::K_ASSIGN;
            kot_pkg::PC_GT:     kind = kot_pkg::K_GEQ;
            kot_pkg::PC_LT:     kind = kot_pkg::K_LEQ;
            default:            kind = kot_pkg::K_IDENT;
        endcase
        return make_word(kind, start, l, wrapped);
    endfunction

    // ---------------------------------------------------------------- input register

    logic                 src_valid_reg;
    kot_pkg::src_word_t   src_word_reg;
    logic                 room;
    logic                 fire;

    logic [CW-1:0]        count_reg;
    logic [CW-1:0]        count_next;
    logic [QW-1:0]        wr_ptr_reg;
    logic [QW-1:0]        wr_ptr_next;
    logic [QW-1:0]        rd_ptr_reg;
    logic [QW-1:0]        rd_ptr_next;
    kot_pkg::tok_word_t   queue_reg [kot_pkg::QUEUE_DEPTH];

    assign room = count_reg <= CW'(kot_pkg::QUEUE_DEPTH - kot_pkg::MAX_PER_ITEM);
    assign fire = src_valid_reg && room;
    assign src_stall = src_valid_reg && !room;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            src_valid_reg <= 1'b0;
        end
        else if (!src_stall)
        begin
            src_valid_reg <= src_valid;
        end
    end

    always_ff @(posedge clk) begin
        if (!src_stall && src_valid)
        begin
            src_word_reg <= src_data;
        end
    end

    // ---------------------------------------------------------------- lexer state

    kot_pkg::pclass_t          pclass_reg, pclass_next;
    logic [OFFSET_WIDTH-1:0]   pstart_reg, pstart_next;
    logic [LEN_W-1:0]          plen_reg, plen_next;
    logic [3:0]                kwflags_reg, kwflags_next;
    logic [OFFSET_WIDTH-1:0]   offset_reg, offset_next;
    logic                      wrapped_reg, wrapped_next;

    // candidates in output order: byte token, operator, end flush, eof
    logic [3:0]                cand_v;
    kot_pkg::tok_word_t        cand_w [4];
    logic [1:0]                slot [4];
    logic [2:0]                push_cnt;
    logic                      pop;

    always_comb begin
        logic [7:0]  c;
        logic [5:0]  op;
        logic [4:0]  two_kind;

        c = src_word_reg.char_byte;
        op = kot_pkg::op_kind(c);
        two_kind = kot_pkg::K_ASSIGN;

        pclass_next = pclass_reg;
        pstart_next = pstart_reg;
        plen_next = plen_reg;
        kwflags_next = kwflags_reg;
        offset_next = offset_reg;
        wrapped_next = wrapped_reg;
        cand_v = '0;
        for (int i = 0; i < 4; i++)
            cand_w[i] = make_word(kot_pkg::K_EOF, offset_reg, '0, wrapped_reg);

        if (src_word_reg.has_byte)
        begin
            if (pclass_reg == kot_pkg::PC_IDENT &&
                (kot_pkg::is_alpha(c) || kot_pkg::is_digit(c) || c == kot_pkg::CH_US))
            begin
                kwflags_next = kw_step(plen_reg, kwflags_reg, c);
                plen_next = len_inc(plen_reg);
            end
            else if (pclass_reg == kot_pkg::PC_NUMBER && kot_pkg::is_digit(c))
            begin
                plen_next = len_inc(plen_reg);
            end
            else if ((pclass_reg == kot_pkg::PC_EQ || pclass_reg == kot_pkg::PC_GT ||
                      pclass_reg == kot_pkg::PC_LT) && c == kot_pkg::CH_EQ)
            begin
                if (pclass_reg == kot_pkg::PC_GT)
                    two_kind = kot_pkg::K_GEQ;
                else if (pclass_reg == kot_pkg::PC_LT)
                    two_kind = kot_pkg::K_LEQ;
                cand_v[0] = 1'b1;
                cand_w[0] = make_word(two_kind, pstart_reg, LEN_W'(2), wrapped_reg);
                pclass_next = kot_pkg::PC_NONE;
                plen_next = '0;
            end
            else
            begin
                cand_v[0] = pclass_reg != kot_pkg::PC_NONE;
                cand_w[0] = flush_word(pclass_reg, pstart_reg, plen_reg, kwflags_reg,
                                       wrapped_reg);
                pclass_next = kot_pkg::PC_NONE;
                plen_next = '0;
                kwflags_next = '1;
                if (!kot_pkg::is_space(c))
                begin
                    priority if (kot_pkg::is_alpha(c))
                    begin
                        pclass_next = kot_pkg::PC_IDENT;
                        pstart_next = offset_reg;
                        kwflags_next = kw_step('0, 4'hF, c);
                        plen_next = LEN_W'(1);
                    end
                    else if (kot_pkg::is_digit(c))
                    begin
                        pclass_next = kot_pkg::PC_NUMBER;
                        pstart_next = offset_reg;
                        plen_next = LEN_W'(1);
                    end
                    else if (c == kot_pkg::CH_EQ || c == kot_pkg::CH_GT ||
                             c == kot_pkg::CH_LT)
                    begin
                        pclass_next = (c == kot_pkg::CH_EQ) ? kot_pkg::PC_EQ :
                                      (c == kot_pkg::CH_GT) ? kot_pkg::PC_GT :
                                                              kot_pkg::PC_LT;
                        pstart_next = offset_reg;
                        plen_next = LEN_W'(1);
                    end
                    else
                    begin
                        // unknown bytes just fall out here
                        cand_v[1] = op[5];
                        cand_w[1] = make_word(op[4:0], offset_reg, LEN_W'(1), wrapped_reg);
                    end
                end
            end
            if (offset_reg == OFF_MAX)
                wrapped_next = 1'b1;
            offset_next = offset_reg + OFFSET_WIDTH'(1);
        end

        if (src_word_reg.end_of_input)
        begin
            cand_v[2] = pclass_next != kot_pkg::PC_NONE;
            cand_w[2] = flush_word(pclass_next, pstart_next, plen_next, kwflags_next,
                                   wrapped_next);
            cand_v[3] = 1'b1;
            cand_w[3] = make_word(kot_pkg::K_EOF, offset_next, '0, wrapped_next);
            pclass_next = kot_pkg::PC_NONE;
            pstart_next = '0;
            plen_next = '0;
            kwflags_next = '1;
            offset_next = '0;
            wrapped_next = 1'b0;
        end

        // mark the final word of this source word
        if (cand_v[3])
            cand_w[3].last_of_run = 1'b1;
        else if (cand_v[1])
            cand_w[1].last_of_run = 1'b1;
        else
            cand_w[0].last_of_run = 1'b1;

        slot[0] = 2'd0;
        slot[1] = 2'(cand_v[0]);
        slot[2] = 2'(cand_v[0]) + 2'(cand_v[1]);
        slot[3] = 2'(cand_v[0]) + 2'(cand_v[1]) + 2'(cand_v[2]);
        push_cnt = fire ? 3'(slot[3]) + 3'(cand_v[3]) : 3'd0;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            pclass_reg <= kot_pkg::PC_NONE;
            pstart_reg <= '0;
            plen_reg <= '0;
            kwflags_reg <= '1;
            offset_reg <= '0;
            wrapped_reg <= 1'b0;
        end
        else if (fire)
        begin
            pclass_reg <= pclass_next;
            pstart_reg <= pstart_next;
            plen_reg <= plen_next;
            kwflags_reg <= kwflags_next;
            offset_reg <= offset_next;
            wrapped_reg <= wrapped_next;
        end
    end

    // ---------------------------------------------------------------- result queue

    assign tok_valid = count_reg != '0;
    assign tok_data = queue_reg[rd_ptr_reg];
    assign pop = tok_valid && !tok_stall;

    always_comb begin
        wr_ptr_next = wr_ptr_reg + QW'(push_cnt);
        rd_ptr_next = rd_ptr_reg + QW'(pop);
        count_next = count_reg + CW'(push_cnt) - CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk) begin
        for (int i = 0; i < 4; i++) begin
            if (fire && cand_v[i])
                queue_reg[wr_ptr_reg + QW'(slot[i])] <= cand_w[i];
        end
    end

    // ---------------------------------------------------------------- checks

    logic       end_fire;
    logic       pushing;
    logic       state_idle;
    logic [3:0] last_mask;

    assign end_fire   = fire && src_word_reg.end_of_input;
    assign pushing    = fire && push_cnt != 3'd0;
    assign state_idle = pclass_reg == kot_pkg::PC_NONE && offset_reg == '0 && !wrapped_reg;
    assign last_mask  = cand_v & {cand_w[3].last_of_run, cand_w[2].last_of_run,
                                  cand_w[1].last_of_run, cand_w[0].last_of_run};

    `KOT_ASSERT_ALWAYS(a_queue_bound, count_reg <= QDEPTH, "result queue overflow")
    `KOT_ASSERT_IMPL(a_one_last, pushing, $countones(last_mask) == 1, "one last word per run")
    `KOT_ASSERT_NEXT(a_end_resets, end_fire, state_idle, "end did not clear state")
    `KOT_ASSERT_NEXT(a_wrap_sticky, wrapped_reg && !end_fire, wrapped_reg, "wrap flag dropped")
    `KOT_ASSERT_NEXT(a_pop_only, pop && !fire, count_reg == $past(count_reg) - CW'(1), "pop count")

endmodule

[tb/sv/token_stream_checker.sv]
// ----------------------------------------------------------------------------
// token_stream_checker
// Watches the source and token channels of the tokenizer, keeps its own
// lexer state, predicts the tokens of every accepted source word and
// compares each accepted token word, field by field, with the oldest
// prediction.
// ----------------------------------------------------------------------------
module token_stream_checker
    import kot_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      src_valid,
    input  logic      src_stall,
    input  src_word_t src_data,
    input  logic      tok_valid,
    input  logic      tok_stall,
    input  tok_word_t tok_data,
    output int        fail_count,
    output int        backlog
);

    localparam int          TOK_LEN_MAX = 255;
    localparam logic [15:0] OFFSET_TOP  = 16'hFFFF;

    // lexer state
    pclass_t     pend_cls;
    logic [15:0] pend_start;
    logic [7:0]  pend_len;
    logic [3:0]  kw_alive;
    logic [15:0] byte_off;
    logic        off_wrapped;

    tok_word_t   expected_toks[$];
    tok_word_t   run_toks[$];
    tok_word_t   want;
    int          mism_count;

    function automatic string kw_spelling(int k);
        case (k)
            0:       return "if";
            1:       return "else";
            2:       return "while";
            default: return "print";
        endcase
    endfunction

    function automatic void clear_state();
        pend_cls    = PC_NONE;
        pend_start  = '0;
        pend_len    = '0;
        kw_alive    = 4'hF;
        byte_off    = '0;
        off_wrapped = 1'b0;
    endfunction

    function automatic void push_tok(logic [4:0] kind, logic [15:0] start, logic [7:0] len);
        tok_word_t t;
        t.token_kind     = kind;
        t.token_start    = start;
        t.token_length   = len;
        t.last_of_run    = 1'b0;
        t.offset_wrapped = off_wrapped;
        run_toks.insert(run_toks.size(), t);
    endfunction

    // narrow the keyword candidates by the next identifier character
    function automatic void take_ident_char(logic [7:0] c);
        string w;
        for (int k = 0; k < 4; k++)
        begin
            w = kw_spelling(k);
            if (!(pend_len < w.len() && w[pend_len] == c))
                kw_alive[k] = 1'b0;
        end
        if (pend_len < TOK_LEN_MAX)
            pend_len++;
    endfunction

    function automatic void flush_pending();
        logic [4:0] kind;
        string      w;
        kind = K_IDENT;
        case (pend_cls)
            PC_IDENT:
            begin
                for (int k = 0; k < 4; k++)
                begin
                    w = kw_spelling(k);
                    if (kw_alive[k] && pend_len == w.len())
                        kind = K_IF + 5'(k);
                end
                push_tok(kind, pend_start, pend_len);
            end
            PC_NUMBER: push_tok(K_NUMBER, pend_start, pend_len);
            PC_EQ:     push_tok(K_ASSIGN, pend_start, 8'd1);
            PC_GT:     push_tok(K_GEQ, pend_start, 8'd1);
            PC_LT:     push_tok(K_LEQ, pend_start, 8'd1);
            default:   ;
        endcase
        pend_cls = PC_NONE;
        pend_len = '0;
        kw_alive = 4'hF;
    endfunction

    function automatic void lex_source_word(src_word_t w);
        logic [7:0]  c;
        logic [15:0] off;
        logic [4:0]  op;
        logic        op_hit;
        logic        is_let;
        logic        is_dig;
        c = w.char_byte;
        run_toks.delete();
        if (w.has_byte)
        begin
            off    = byte_off;
            is_let = c inside {[8'h61:8'h7A], [8'h41:8'h5A]};
            is_dig = c inside {[8'h30:8'h39]};
            if (pend_cls == PC_IDENT && (is_let || is_dig || c == CH_US))
                take_ident_char(c);
            else if (pend_cls == PC_NUMBER && is_dig)
            begin
                if (pend_len < TOK_LEN_MAX)
                    pend_len++;
            end
            else if (pend_cls inside {PC_EQ, PC_GT, PC_LT} && c == CH_EQ)
            begin
                push_tok(pend_cls == PC_EQ ? K_ASSIGN : (pend_cls == PC_GT ? K_GEQ : K_LEQ),
                         pend_start, 8'd2);
                pend_cls = PC_NONE;
                pend_len = '0;
            end
            else
            begin
                flush_pending();
                // blanks and unknown bytes start nothing
                if (is_let)
                begin
                    pend_cls   = PC_IDENT;
                    pend_start = off;
                    pend_len   = '0;
                    kw_alive   = 4'hF;
                    take_ident_char(c);
                end
                else if (is_dig || c == CH_EQ || c == CH_GT || c == CH_LT)
                begin
                    pend_cls   = is_dig ? PC_NUMBER : (c == CH_EQ ? PC_EQ :
                                 (c == CH_GT ? PC_GT : PC_LT));
                    pend_start = off;
                    pend_len   = 8'd1;
                end
                else
                begin
                    op_hit = 1'b1;
                    op     = K_IDENT;
                    case (c)
                        "+":     op = K_PLUS;
                        "-":     op = K_MINUS;
                        "*":     op = K_MUL;
                        "/":     op = K_DIV;
                        "(":     op = K_LPAREN;
                        ")":     op = K_RPAREN;
                        "{":     op = K_LBRACE;
                        "}":     op = K_RBRACE;
                        default: op_hit = 1'b0;
                    endcase
                    if (op_hit)
                        push_tok(op, off, 8'd1);
                end
            end
            if (off == OFFSET_TOP)
                off_wrapped = 1'b1;
            byte_off = off + 16'd1;
        end
        if (w.end_of_input)
        begin
            flush_pending();
            push_tok(K_EOF, byte_off, 8'd0);
            clear_state();
        end
        if (run_toks.size() > 0)
            run_toks[run_toks.size() - 1].last_of_run = 1'b1;
        foreach (run_toks[i])
            expected_toks.insert(expected_toks.size(), run_toks[i]);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_state();
            expected_toks.delete();
            mism_count = 0;
            fail_count <= 0;
            backlog    <= 0;
        end
        else
        begin
            if (src_valid && !src_stall)
                lex_source_word(src_data);
            if (tok_valid && !tok_stall)
            begin
                if (expected_toks.size() == 0)
                begin
                    mism_count++;
                    if (mism_count <= 10)
                        $display("token word with none expected: kind=%0d start=%0d len=%0d",
                                 tok_data.token_kind, tok_data.token_start,
                                 tok_data.token_length);
                end
                else
                begin
                    want = expected_toks.pop_front();
                    if (want !== tok_data)
                    begin
                        mism_count++;
                        if (mism_count <= 10)
                            $display({"token mismatch: exp kind=%0d start=%0d len=%0d last=%0b ",
                                      "wrap=%0b, got kind=%0d start=%0d len=%0d last=%0b wrap=%0b"},
                                     want.token_kind, want.token_start, want.token_length,
                                     want.last_of_run, want.offset_wrapped,
                                     tok_data.token_kind, tok_data.token_start,
                                     tok_data.token_length, tok_data.last_of_run,
                                     tok_data.offset_wrapped);
                    end
                end
            end
            fail_count <= mism_count;
            backlog    <= expected_toks.size();
        end
    end

endmodule

[tb/sv/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the keyword/operator tokenizer: directed text,
// random token streams with noise and idle bursts on both channels, then a
// short stream without idling. Checking is done by token_stream_checker.
// ----------------------------------------------------------------------------
module tb;
    import kot_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int RAND_WORDS  = 60;
    localparam int TAIL_WORDS  = 15;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      src_valid = 1'b0;
    logic      src_stall;
    src_word_t src_data  = '0;
    logic      tok_valid;
    logic      tok_stall = 1'b0;
    tok_word_t tok_data;

    int fail_count;
    int backlog;
    int cycle_count = 0;
    int word_count  = 0;
    int hold_left   = 0;
    bit quiet       = 1'b0;
    bit busy_mode   = 1'b1;
    bit rx_calm     = 1'b0;

    keyword_operator_tokenizer u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .src_data  (src_data),
        .tok_valid (tok_valid),
        .tok_stall (tok_stall),
        .tok_data  (tok_data)
    );

    token_stream_checker u_chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .src_valid  (src_valid),
        .src_stall  (src_stall),
        .src_data   (src_data),
        .tok_valid  (tok_valid),
        .tok_stall  (tok_stall),
        .tok_data   (tok_data),
        .fail_count (fail_count),
        .backlog    (backlog)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // token side stall bursts, with calm stretches
    always @(posedge clk)
    begin
        if ($urandom_range(0, 199) == 0)
            rx_calm = !rx_calm;
        if (quiet || !rst_n)
        begin
            hold_left = 0;
            tok_stall <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            tok_stall <= 1'b1;
        end
        else if (!rx_calm && $urandom_range(0, 11) == 0)
        begin
            hold_left = $urandom_range(0, 18);
            tok_stall <= 1'b1;
        end
        else
            tok_stall <= 1'b0;
    end

    task automatic put_word(input logic hb, input logic [7:0] ch, input logic eoi);
        if (!quiet && busy_mode && $urandom_range(0, 5) == 0)
        begin
            src_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        src_valid <= 1'b1;
        src_data  <= '{has_byte: hb, char_byte: ch, end_of_input: eoi};
        do @(posedge clk); while (src_stall);
        if (hb || eoi)
            word_count++;
        if (word_count % 16 == 0)
            busy_mode = $urandom_range(0, 2) != 0;
    endtask

    task automatic send_text(input string s, input bit finish);
        for (int i = 0; i < s.len(); i++)
            put_word(1'b1, s[i], finish && i == s.len() - 1);
    endtask

    task automatic wait_drained();
        do @(posedge clk); while (backlog != 0);
    endtask

    function automatic logic [7:0] rand_letter();
        if ($urandom_range(0, 1) != 0)
            return 8'(32'h61 + $urandom_range(0, 25));
        return 8'(32'h41 + $urandom_range(0, 25));
    endfunction

    // one well-formed token with random content, or a noise byte
    task automatic put_token();
        int    r;
        string s;
        r = $urandom_range(0, 99);
        if (r < 12)
            put_word(1'b1, 8'($urandom_range(0, 255)), 1'b0);
        else if (r < 24)
        begin
            case ($urandom_range(0, 7))
                0:       s = "if";
                1:       s = "else";
                2:       s = "while";
                3:       s = "print";
                4:       s = "whi";
                5:       s = "elsewhere";
                6:       s = "iff";
                default: s = "pr";
            endcase
            send_text(s, 1'b0);
        end
        else if (r < 44)
        begin
            put_word(1'b1, rand_letter(), 1'b0);
            repeat ($urandom_range(0, 7))
            begin
                case ($urandom_range(0, 3))
                    0:       put_word(1'b1, 8'(32'h30 + $urandom_range(0, 9)), 1'b0);
                    1:       put_word(1'b1, CH_US, 1'b0);
                    default: put_word(1'b1, rand_letter(), 1'b0);
                endcase
            end
        end
        else if (r < 56)
        begin
            repeat ($urandom_range(1, 5))
                put_word(1'b1, 8'(32'h30 + $urandom_range(0, 9)), 1'b0);
        end
        else if (r < 70)
        begin
            s = "+-*/(){}";
            put_word(1'b1, s[$urandom_range(0, 7)], 1'b0);
        end
        else if (r < 86)
        begin
            s = "=<>";
            put_word(1'b1, s[$urandom_range(0, 2)], 1'b0);
            if ($urandom_range(0, 1) != 0)
                put_word(1'b1, CH_EQ, 1'b0);
        end
        else if ($urandom_range(0, 1) != 0)
            put_word(1'b1, 8'h20, 1'b0);
        else
            put_word(1'b1, 8'($urandom_range(9, 13)), 1'b0);
        if ($urandom_range(0, 9) < 5)
            put_word(1'b1, 8'h20, 1'b0);
    endtask

    initial
    begin
        int rand_goal;
        int r;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // keywords, identifier with '_' and digit, all operators but '+', pairs with '='
        send_text("if(a_9)else{while}\tprint-12*3/=", 1'b0);
        send_text("=>=<", 1'b0);
        put_word(1'b1, 8'hFF, 1'b0);   // unknown byte ends the pending '<'
        put_word(1'b1, CH_US, 1'b0);   // '_' at token start is dropped
        put_word(1'b1, 8'h00, 1'b0);
        put_word(1'b1, 8'h0D, 1'b0);
        put_word(1'b0, 8'hA5, 1'b0);   // neither byte nor end
        put_word(1'b1, "+", 1'b0);
        put_word(1'b0, 8'h00, 1'b1);   // empty end marker
        send_text("x=", 1'b1);         // end flushes a lone '='

        src_valid <= 1'b0;
        wait_drained();

        rand_goal = word_count + RAND_WORDS;
        while (word_count < rand_goal)
        begin
            r = $urandom_range(0, 39);
            if (r == 0)
                put_word(1'b0, 8'($urandom_range(0, 255)), 1'b0);
            else if (r == 1)
                put_word(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), 1'b1);
            else
                put_token();
        end

        // no idling from here
        quiet = 1'b1;
        rand_goal = word_count + TAIL_WORDS;
        while (word_count < rand_goal)
            put_token();
        send_text("print", 1'b1);

        src_valid <= 1'b0;
        wait_drained();
        repeat (20) @(posedge clk);
        if (fail_count == 0 && backlog == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

[sim.f]
+incdir+hdl
hdl/kot_pkg.sv
hdl/keyword_operator_tokenizer.sv
tb/sv/token_stream_checker.sv
tb/sv/tb.sv
